// ===== hw/rtl/sierp_pkg.sv =====
// Shared types, lookup tables and packing constants for the Sierpinski curve stepper.
package sierp_pkg;

    // Width of the curve order register.
    localparam int unsigned ORDER_W = 4;
    // Width of the stream data buses, in bits.
    localparam int unsigned IN_DATA_W  = 8;
    localparam int unsigned OUT_DATA_W = 8;

    typedef logic [1:0]        kind_t;
    typedef logic [1:0]        digit_t;
    typedef logic signed [2:0] step_t;

    // Curve kinds of a sub-curve.
    localparam kind_t KIND_URD = 2'd0;
    localparam kind_t KIND_LUR = 2'd1;
    localparam kind_t KIND_DLU = 2'd2;
    localparam kind_t KIND_RDL = 2'd3;

    // Last child digit of a level.
    localparam digit_t DIGIT_LAST = 2'd3;

    localparam step_t STEP_P2 = 3'sd2;
    localparam step_t STEP_P1 = 3'sd1;
    localparam step_t STEP_Z  = 3'sd0;
    localparam step_t STEP_M1 = -3'sd1;
    localparam step_t STEP_M2 = -3'sd2;

    // Control that the top level broadcasts to every cell.
    typedef struct packed {
        logic  step_en;
        logic  load;
        kind_t load_kind;
    } cell_ctl_t;

    // What a cell reports back to the top level.
    typedef struct packed {
        logic  incr;
        step_t step_x;
        step_t step_y;
    } cell_stat_t;

    // One result item as held in the output buffer.
    typedef struct packed {
        step_t step_x;
        step_t step_y;
        logic  pen_down;
        logic  last_segment;
    } out_item_t;

    // Kind of child d of a curve of kind k.
    function automatic kind_t child_kind(input kind_t k, input digit_t d);
        kind_t r;
        r = k;
        case (k)
            KIND_URD: r = (d == 2'd1) ? KIND_LUR : ((d == 2'd2) ? KIND_RDL : KIND_URD);
            KIND_LUR: r = (d == 2'd1) ? KIND_DLU : ((d == 2'd2) ? KIND_URD : KIND_LUR);
            KIND_DLU: r = (d == 2'd1) ? KIND_RDL : ((d == 2'd2) ? KIND_LUR : KIND_DLU);
            default:  r = (d == 2'd1) ? KIND_URD : ((d == 2'd2) ? KIND_DLU : KIND_RDL);
        endcase
        return r;
    endfunction

    // X part of the connector after child d of a curve of kind k.
    function automatic step_t conn_dx(input kind_t k, input digit_t d);
        step_t r;
        r = STEP_Z;
        case (k)
            KIND_URD: r = (d == 2'd1) ? STEP_P2 : STEP_P1;
            KIND_LUR: r = (d == 2'd0) ? STEP_M1 : ((d == 2'd1) ? STEP_Z : STEP_P1);
            KIND_DLU: r = (d == 2'd1) ? STEP_M2 : STEP_M1;
            default:  r = (d == 2'd0) ? STEP_P1 : ((d == 2'd1) ? STEP_Z : STEP_M1);
        endcase
        return r;
    endfunction

    // Y part of the connector after child d of a curve of kind k.
    function automatic step_t conn_dy(input kind_t k, input digit_t d);
        step_t r;
        r = STEP_Z;
        case (k)
            KIND_URD: r = (d == 2'd0) ? STEP_P1 : ((d == 2'd1) ? STEP_Z : STEP_M1);
            KIND_LUR: r = (d == 2'd1) ? STEP_P2 : STEP_P1;
            KIND_DLU: r = (d == 2'd0) ? STEP_M1 : ((d == 2'd1) ? STEP_Z : STEP_P1);
            default:  r = (d == 2'd1) ? STEP_M2 : STEP_M1;
        endcase
        return r;
    endfunction

    // Connector after each top-level quarter.
    function automatic step_t top_dx(input kind_t q);
        return (q == KIND_URD || q == KIND_RDL) ? STEP_P1 : STEP_M1;
    endfunction

    function automatic step_t top_dy(input kind_t q);
        return (q == KIND_URD || q == KIND_LUR) ? STEP_P1 : STEP_M1;
    endfunction

endpackage

// ===== hw/rtl/sierp_cell.sv =====
// One recursion level of the curve stack: curve kind and child digit.
module sierp_cell
    import sierp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctl_t  ctl,
    input  logic       active,
    input  logic       carry_in,
    input  kind_t      kind_in,
    output logic       carry_out,
    output kind_t      kind_out,
    output cell_stat_t stat
);

    kind_t  kind_reg,  kind_next;
    digit_t digit_reg, digit_next;
    logic   is_last;
    logic   incr;
    logic   restart_here;

    // Priority carry: this level moves on when every deeper active level is done.
    assign is_last      = (digit_reg == DIGIT_LAST);
    assign incr         = active && carry_in && !is_last;
    assign restart_here = active && carry_in && is_last;
    assign carry_out    = active ? (carry_in && is_last) : 1'b1;

    // The level that moves on hands its new child kind down; restarted levels pass it on.
    assign kind_out = incr ? child_kind(kind_reg, digit_reg + 2'd1) : kind_in;

    assign stat.incr   = incr;
    assign stat.step_x = conn_dx(kind_reg, digit_reg);
    assign stat.step_y = conn_dy(kind_reg, digit_reg);

    // Next level state.
    always_comb
    begin
        kind_next  = kind_reg;
        digit_next = digit_reg;
        if (ctl.load)
        begin
            kind_next  = ctl.load_kind;
            digit_next = '0;
        end
        else if (ctl.step_en && incr)
        begin
            digit_next = digit_reg + 2'd1;
        end
        else if (ctl.step_en && restart_here)
        begin
            kind_next  = kind_in;
            digit_next = '0;
        end
    end

    // Level registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg  <= KIND_URD;
            digit_reg <= '0;
        end
        else
        begin
            kind_reg  <= kind_next;
            digit_reg <= digit_next;
        end
    end

endmodule

// ===== hw/rtl/sierp_obuf.sv =====
// Two-entry output buffer that parts the segment generator from the output stream.
module sierp_obuf
    import sierp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  out_item_t push_item,
    output logic      push_ready,
    output logic      pop_valid,
    input  logic      pop_ready,
    output out_item_t pop_item
);

    out_item_t  slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg,  count_next;
    logic       pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop        = pop_valid && pop_ready;
    assign pop_item   = slot_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Payload slots.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== hw/rtl/sierpinski_curve_stepper_unit.sv =====
// Top level of the Sierpinski curve stepper: config register, cell chain and output buffer.
//
// Each accepted input item with advance set yields one segment of the closed Sierpinski
// curve, one item per cycle unless the output stalls; the segment is written to the output
// buffer at acceptance. An item with advance clear is taken and yields nothing. The first
// segment is the pen-up move to the start point (1, 0); then come the four quarters, each
// closed by its diagonal connector, and the closing segment carries tlast. Steps are in
// units of the grid step h. The recursion stack is a chain of MAX_ORDER level cells whose
// carry ripples through the chain within the cycle, which sets the clock period. Writing
// the curve order (saturated to MAX_ORDER) restarts the curve; write it only while idle.
module sierpinski_curve_stepper_unit
    import sierp_pkg::*;
#(
    parameter int unsigned MAX_ORDER = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Configuration write: curve_order.
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [ORDER_W-1:0]    cfg_data,
    // Input stream. tdata fields from bit 0: advance.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // Output stream. tdata fields from bit 0: step_x, step_y. tuser fields: pen_down.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tuser,
    output logic                  m_tlast
);

    localparam int unsigned LVL_W = $clog2(MAX_ORDER + 1);
    // Compare width that holds both the order register and the built depth.
    localparam int unsigned CMP_W = (LVL_W > ORDER_W) ? LVL_W : ORDER_W;

    logic [ORDER_W-1:0] order_reg,   order_next;
    kind_t              quarter_reg, quarter_next;
    logic               started_reg, started_next;

    logic [LVL_W-1:0]   eff_order;
    logic               cfg_write;
    logic               accept;
    logic               advance;
    logic               found;
    cell_ctl_t          ctl;
    out_item_t          seg;
    step_t              sel_x;
    step_t              sel_y;

    logic               carry  [MAX_ORDER+1];
    kind_t              kind_o [MAX_ORDER];
    cell_stat_t         stat   [MAX_ORDER];

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign accept    = s_tvalid && s_tready;
    assign advance   = s_tdata[0];

    // Saturate the order to the built depth.
    assign eff_order = (CMP_W'(order_reg) > CMP_W'(MAX_ORDER)) ? LVL_W'(MAX_ORDER)
                                                                : LVL_W'(order_reg);

    // Chain of level cells, deepest carry enters at the far end.
    assign carry[MAX_ORDER] = 1'b1;
    assign found            = !carry[0];

    for (genvar m = 0; m < MAX_ORDER; m++)
    begin : g_cell
        kind_t kind_i;
        if (m == 0)
        begin : g_head
            assign kind_i = KIND_URD;
        end
        else
        begin : g_link
            assign kind_i = kind_o[m-1];
        end

        sierp_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .active    (LVL_W'(m) < eff_order),
            .carry_in  (carry[m+1]),
            .kind_in   (kind_i),
            .carry_out (carry[m]),
            .kind_out  (kind_o[m]),
            .stat      (stat[m])
        );
    end

    // Pick the connector of the level that moves on; at most one cell reports it.
    always_comb
    begin
        sel_x = STEP_Z;
        sel_y = STEP_Z;
        for (int m = 0; m < MAX_ORDER; m++)
        begin
            if (stat[m].incr)
            begin
                sel_x = sel_x | stat[m].step_x;
                sel_y = sel_y | stat[m].step_y;
            end
        end
    end

    // Segment selection, cell control and top-level state.
    always_comb
    begin
        order_next    = order_reg;
        quarter_next  = quarter_reg;
        started_next  = started_reg;
        ctl.step_en   = 1'b0;
        ctl.load      = 1'b0;
        ctl.load_kind = KIND_URD;

        seg.step_x       = STEP_P1;
        seg.step_y       = STEP_Z;
        seg.pen_down     = 1'b0;
        seg.last_segment = 1'b0;

        if (started_reg)
        begin
            seg.pen_down = 1'b1;
            if (found)
            begin
                seg.step_x = sel_x;
                seg.step_y = sel_y;
            end
            else
            begin
                seg.step_x       = top_dx(quarter_reg);
                seg.step_y       = top_dy(quarter_reg);
                seg.last_segment = (quarter_reg == KIND_RDL);
            end
        end

        if (cfg_write)
        begin
            // A new order restarts the curve.
            order_next    = cfg_data;
            quarter_next  = KIND_URD;
            started_next  = 1'b0;
            ctl.load      = 1'b1;
            ctl.load_kind = KIND_URD;
        end
        else if (accept && advance)
        begin
            if (!started_reg)
            begin
                started_next = 1'b1;
            end
            else if (found)
            begin
                ctl.step_en = 1'b1;
            end
            else
            begin
                // Next quarter; after the closing one the curve starts over.
                quarter_next  = quarter_reg + 2'd1;
                ctl.load      = 1'b1;
                ctl.load_kind = quarter_reg + 2'd1;
                if (quarter_reg == KIND_RDL)
                begin
                    started_next = 1'b0;
                end
            end
        end
    end

    // Top-level registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg   <= ORDER_W'(1);
            quarter_reg <= KIND_URD;
            started_reg <= 1'b0;
        end
        else
        begin
            order_reg   <= order_next;
            quarter_reg <= quarter_next;
            started_reg <= started_next;
        end
    end

    // Output buffer.
    out_item_t out_item;

    sierp_obuf u_obuf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (accept && advance),
        .push_item  (seg),
        .push_ready (s_tready),
        .pop_valid  (m_tvalid),
        .pop_ready  (m_tready),
        .pop_item   (out_item)
    );

    assign m_tdata = {{(OUT_DATA_W - 6){1'b0}}, out_item.step_y, out_item.step_x};
    assign m_tuser = out_item.pen_down;
    assign m_tlast = out_item.last_segment;

endmodule

// ===== hw/rtl/sierp_checker.sv =====
// Port-level checker for the Sierpinski curve stepper, bound to the top level.
module sierp_checker
    import sierp_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic                  m_tuser,
    input logic                  m_tlast
);

    // A stalled output keeps its valid asserted.
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output item dropped while stalled");

    // Both steps stay within two grid steps.
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[2:0] != 3'b011 && m_tdata[2:0] != 3'b100 &&
                      m_tdata[2:0] != 3'b101 && m_tdata[5:3] != 3'b011 &&
                      m_tdata[5:3] != 3'b100 && m_tdata[5:3] != 3'b101))
        else $error("step out of range");

    // The pen-up item is always the move to the start point.
    a_start_move: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> (m_tdata[5:0] == 6'b000001) && !m_tlast)
        else $error("bad start move");

    // The closing item is the down-right diagonal with the pen down.
    a_close_move: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tuser && (m_tdata[5:0] == 6'b111001))
        else $error("bad closing segment");

endmodule

bind sierpinski_curve_stepper_unit sierp_checker u_sierp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
